[sv/length_prefixed_field_extractor_top_defines.svh]
// Assertion macros used by the checker file of the field extractor.
`ifndef LENGTH_PREFIXED_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// Concurrent assertion sampled on clk, ignored while rst_n is low.
`define LPFE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion sampled on clk that also holds through reset.
`define LPFE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/lpfe_pkg.sv]
// Types and constants of the length-prefixed field extractor.
`default_nettype none
package lpfe_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 32;
  localparam int KIND_W  = 3;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE   = 3'd0,
    KIND_LAST   = 3'd1,
    KIND_EMPTY  = 3'd2,
    KIND_ABSENT = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  payload;
    logic [VALUE_W-1:0] value;
  } result_t;

  // Int value collects the first three payload bytes, and a fourth only for length four.
  localparam logic [BYTE_W-1:0] VALUE_BYTES   = 8'd3;
  localparam logic [BYTE_W-1:0] FULL_WORD_LEN = 8'd4;

endpackage
`default_nettype wire

[sv/lpfe_parser.sv]
// Front end: accepts message bytes, tracks the field walk and classifies results.
`default_nettype none
module lpfe_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lpfe_pkg::BYTE_W-1:0]    cfg_wr_data,
  input  wire logic                           byte_accept,
  input  wire logic [lpfe_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic [lpfe_pkg::BYTE_W-1:0]    buffer_length,
  output logic                                res_valid,
  output lpfe_pkg::result_t                   res
);
  import lpfe_pkg::*;

  logic [BYTE_W-1:0]  field_skip_r;
  logic [BYTE_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0]  decl_r, decl_nxt;
  logic [BYTE_W-1:0]  skip_r, skip_nxt;
  logic [BYTE_W-1:0]  left_r, left_nxt;
  logic [BYTE_W-1:0]  sel_r, sel_nxt;
  phase_t             phase_r, phase_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;

  logic [BYTE_W-1:0]  blen;
  logic [BYTE_W:0]    pos_plus_b;
  logic [BYTE_W:0]    pos_plus_1;
  logic [BYTE_W-1:0]  left_dec;
  logic [BYTE_W-1:0]  idx;
  logic [VALUE_W-1:0] acc_upd;

  always_comb begin
    blen       = (buffer_length == '0) ? BYTE_W'(1) : buffer_length;
    pos_plus_b = {1'b0, pos_r} + {1'b0, data_byte};
    pos_plus_1 = {1'b0, pos_r} + (BYTE_W+1)'(1);
    left_dec   = (left_r != '0) ? left_r - BYTE_W'(1) : '0;
    idx        = sel_r - left_r;
    if (idx < VALUE_BYTES || (idx == VALUE_BYTES && sel_r == FULL_WORD_LEN)) begin
      acc_upd = {acc_r[VALUE_W-BYTE_W-1:0], data_byte};
    end else begin
      acc_upd = acc_r;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    decl_nxt  = decl_r;
    skip_nxt  = skip_r;
    left_nxt  = left_r;
    sel_nxt   = sel_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    res_valid = 1'b0;
    res       = '{kind: KIND_BYTE, payload: '0, value: '0};
    if (byte_accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          decl_nxt = data_byte;
          skip_nxt = field_skip_r;
          if (blen == BYTE_W'(1)) begin
            res_valid = 1'b1;
            res.kind  = KIND_ABSENT;
            phase_nxt = PH_DISCARD;
          end else if (data_byte > blen || data_byte <= BYTE_W'(1)) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            phase_nxt = PH_DISCARD;
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (pos_plus_b >= {1'b0, decl_r}) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            phase_nxt = PH_DISCARD;
          end else if (skip_r != '0) begin
            skip_nxt = skip_r - BYTE_W'(1);
            if (data_byte == '0) begin
              if (pos_plus_1 >= {1'b0, decl_r}) begin
                res_valid = 1'b1;
                res.kind  = KIND_ABSENT;
                phase_nxt = PH_DISCARD;
              end
            end else begin
              left_nxt  = data_byte;
              phase_nxt = PH_SKIP;
            end
          end else if (data_byte == '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
            phase_nxt = PH_DISCARD;
          end else begin
            sel_nxt   = data_byte;
            left_nxt  = data_byte;
            acc_nxt   = '0;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_SKIP: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            if (pos_plus_1 >= {1'b0, decl_r}) begin
              res_valid = 1'b1;
              res.kind  = KIND_ABSENT;
              phase_nxt = PH_DISCARD;
            end else begin
              phase_nxt = PH_LENGTH;
            end
          end
        end
        PH_PAYLOAD: begin
          acc_nxt     = acc_upd;
          left_nxt    = left_dec;
          res_valid   = 1'b1;
          res.payload = data_byte;
          if (left_dec == '0) begin
            res.kind  = KIND_LAST;
            res.value = acc_upd;
            phase_nxt = PH_DISCARD;
          end else begin
            res.kind  = KIND_BYTE;
          end
        end
        PH_DISCARD: begin
          phase_nxt = PH_DISCARD;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
      // Message boundary wins over whatever the phase decided.
      if (pos_plus_1 >= {1'b0, blen}) begin
        pos_nxt   = '0;
        phase_nxt = PH_HEADER;
      end else begin
        pos_nxt   = pos_plus_1[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_skip_r <= '0;
      pos_r        <= '0;
      decl_r       <= '0;
      skip_r       <= '0;
      left_r       <= '0;
      sel_r        <= '0;
      phase_r      <= PH_HEADER;
      acc_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        field_skip_r <= cfg_wr_data;
      end
      pos_r   <= pos_nxt;
      decl_r  <= decl_nxt;
      skip_r  <= skip_nxt;
      left_r  <= left_nxt;
      sel_r   <= sel_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/lpfe_queue.sv]
// Result queue between the parser and the output channel.
`default_nettype none
module lpfe_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lpfe_pkg::result_t push_data,
  output logic                   full,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output lpfe_pkg::result_t      pop_data
);
  import lpfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full      = (count_r == CNT_W'(DEPTH));
    pop_valid = (count_r != '0);
    pop_data  = slots_r[rd_ptr_r];
    do_push   = push && !full;
    do_pop    = pop_valid && pop_ready;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/length_prefixed_field_extractor_top.sv]
// Top level of the length-prefixed field extractor: parser, result queue, stream ports.
// Results: a result is pushed into the result queue when its byte is accepted and is registered there before output.
// Throughput: one byte per cycle; the parser decides each byte combinationally and
//   in_tready drops only while the QUEUE_DEPTH-entry result queue is full.
// Reset: synchronous, active low; clears the parse state, field_skip and the queue.
`default_nettype none
module length_prefixed_field_extractor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,   // field_skip
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,      // data_byte[7:0], buffer_length[15:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,     // payload_byte[7:0], int_value[39:8]
  output logic [2:0]       out_tuser      // kind[2:0]
);
  import lpfe_pkg::*;

  logic    queue_full;
  logic    byte_accept;
  logic    res_valid;
  result_t res;
  result_t head;

  assign in_tready   = !queue_full;
  assign byte_accept = in_tvalid && in_tready;

  lpfe_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .byte_accept   (byte_accept),
    .data_byte     (in_tdata[7:0]),
    .buffer_length (in_tdata[15:8]),
    .res_valid     (res_valid),
    .res           (res)
  );

  lpfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (queue_full),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tdata = {head.value, head.payload};
  assign out_tuser = head.kind;

endmodule
`default_nettype wire

[sv/lpfe_checker.sv]
// Port-level checker for the field extractor, bound to its top level.
`default_nettype none
`include "length_prefixed_field_extractor_top_defines.svh"
module lpfe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import lpfe_pkg::*;

  `LPFE_ASSERT_ALWAYS(a_idle_after_reset, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `LPFE_ASSERT(a_value_only_on_last, clk, rst_n, out_tvalid && out_tuser != KIND_LAST |-> out_tdata[39:8] == '0, "int value outside final byte")
  `LPFE_ASSERT(a_status_no_payload, clk, rst_n, out_tvalid && (out_tuser == KIND_EMPTY || out_tuser == KIND_ABSENT || out_tuser == KIND_ERROR) |-> out_tdata == '0, "status result carries data")
  `LPFE_ASSERT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind length_prefixed_field_extractor_top lpfe_checker u_lpfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench of the length-prefixed field extractor, run against a local predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfe_pkg::*;

  localparam int SETTLE_CYCLES    = 4;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int PHASE_BYTES      = 160;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int NUM_PHASES       = 8;

  typedef enum logic [1:0] {STEP_PREDICT, STEP_TYPED, STEP_SET_SKIP} step_op_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    step_op_t   op;
    logic [7:0] data;    // message byte, or the new field_skip for STEP_SET_SKIP
    logic [7:0] blen;
    kind_t      kind;    // typed status, used by STEP_TYPED only
  } step_row_t;

  localparam int DIR_ROWS = 33;
  step_row_t directed_rows [DIR_ROWS] = '{
    '{STEP_TYPED,    8'h00, 8'd1, KIND_ABSENT},   // one-byte message
    '{STEP_TYPED,    8'hFF, 8'd0, KIND_ABSENT},   // zero buffer length counts as one
    '{STEP_TYPED,    8'h03, 8'd2, KIND_ERROR},    // declared length beyond the buffer
    '{STEP_PREDICT,  8'h12, 8'd2, KIND_BYTE},
    '{STEP_TYPED,    8'h01, 8'd2, KIND_ERROR},    // declared length one
    '{STEP_PREDICT,  8'hAA, 8'd2, KIND_BYTE},
    '{STEP_TYPED,    8'h00, 8'd2, KIND_ERROR},    // declared length zero
    '{STEP_PREDICT,  8'h55, 8'd2, KIND_BYTE},
    '{STEP_PREDICT,  8'h02, 8'd2, KIND_BYTE},
    '{STEP_TYPED,    8'h00, 8'd2, KIND_EMPTY},    // selected field of length zero
    '{STEP_PREDICT,  8'h03, 8'd3, KIND_BYTE},
    '{STEP_TYPED,    8'h02, 8'd3, KIND_ERROR},    // last field byte one past the end
    '{STEP_PREDICT,  8'h77, 8'd3, KIND_BYTE},
    '{STEP_PREDICT,  8'h06, 8'd6, KIND_BYTE},     // four-byte field, full word value
    '{STEP_PREDICT,  8'h04, 8'd6, KIND_BYTE},
    '{STEP_PREDICT,  8'hDE, 8'd6, KIND_BYTE},
    '{STEP_PREDICT,  8'hAD, 8'd6, KIND_BYTE},
    '{STEP_PREDICT,  8'hBE, 8'd6, KIND_BYTE},
    '{STEP_PREDICT,  8'hEF, 8'd6, KIND_BYTE},
    '{STEP_PREDICT,  8'h06, 8'd6, KIND_BYTE},     // buffer length shrinks mid-message
    '{STEP_PREDICT,  8'h03, 8'd2, KIND_BYTE},
    '{STEP_SET_SKIP, 8'h01, 8'd0, KIND_BYTE},
    '{STEP_PREDICT,  8'h05, 8'd5, KIND_BYTE},
    '{STEP_PREDICT,  8'h01, 8'd5, KIND_BYTE},
    '{STEP_PREDICT,  8'h9A, 8'd5, KIND_BYTE},
    '{STEP_PREDICT,  8'h00, 8'd5, KIND_BYTE},
    '{STEP_PREDICT,  8'hBC, 8'd5, KIND_BYTE},
    '{STEP_PREDICT,  8'h03, 8'd3, KIND_BYTE},     // fields run out while skipping
    '{STEP_PREDICT,  8'h01, 8'd3, KIND_BYTE},
    '{STEP_TYPED,    8'h44, 8'd3, KIND_ABSENT},
    '{STEP_SET_SKIP, 8'hFF, 8'd0, KIND_BYTE},
    '{STEP_PREDICT,  8'h02, 8'd2, KIND_BYTE},     // zero-length skipped field at the end
    '{STEP_TYPED,    8'h00, 8'd2, KIND_ABSENT}
  };

  localparam idle_mode_t PHASE_IDLE [NUM_PHASES] = '{
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  };
  localparam int PHASE_SKIP [NUM_PHASES] = '{0, 1, 2, 255, 3, 0, 1, 0};
  localparam bit PHASE_HOLD [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam bit PHASE_BIG  [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  length_prefixed_field_extractor_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // Parser state mirrored by the predictor
  logic [7:0]  pred_field_skip = '0;
  logic [7:0]  pred_pos        = '0;
  logic [7:0]  pred_declared   = '0;
  logic [7:0]  pred_skip_left  = '0;
  logic [7:0]  pred_bytes_left = '0;
  logic [7:0]  pred_field_len  = '0;
  phase_t      pred_phase      = PH_HEADER;
  logic [31:0] pred_value      = '0;

  result_t     pending_results [$];
  logic [15:0] msg_words [$];

  int mismatch_count  = 0;
  int tx_idle_pct     = 0;
  int rx_stall_pct    = 0;
  int long_hold_reqs  = 0;
  int long_holds_done = 0;
  int parsed_bytes    = 0;
  int sent_bytes      = 0;
  int message_count   = 0;
  int skip_writes     = 0;
  int input_stalls    = 0;
  int kind_seen [5]   = '{0, 0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("length_prefixed_field_extractor_top: mismatch");
    $finish;
  end

  // Work out the result one accepted byte causes, advancing the mirrored state.
  function automatic bit predict_field_result(input logic [7:0] b, input logic [7:0] blen_in,
                                              output result_t res);
    int bl;
    int p;
    int bv;
    int ix;
    bit hit;
    bl  = (blen_in == 8'd0) ? 1 : int'(blen_in);
    p   = pred_pos;
    bv  = b;
    hit = 1'b0;
    res = '0;
    case (pred_phase)
      PH_HEADER: begin
        pred_declared  = b;
        pred_skip_left = pred_field_skip;
        if (bl == 1) begin
          hit = 1'b1;
          res.kind = KIND_ABSENT;
          pred_phase = PH_DISCARD;
        end else if (bv > bl || bv <= 1) begin
          hit = 1'b1;
          res.kind = KIND_ERROR;
          pred_phase = PH_DISCARD;
        end else begin
          pred_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (p + bv >= pred_declared) begin
          hit = 1'b1;
          res.kind = KIND_ERROR;
          pred_phase = PH_DISCARD;
        end else if (pred_skip_left != 8'd0) begin
          pred_skip_left = pred_skip_left - 8'd1;
          if (bv == 0) begin
            if (p + 1 >= pred_declared) begin
              hit = 1'b1;
              res.kind = KIND_ABSENT;
              pred_phase = PH_DISCARD;
            end
          end else begin
            pred_bytes_left = b;
            pred_phase = PH_SKIP;
          end
        end else if (bv == 0) begin
          hit = 1'b1;
          res.kind = KIND_EMPTY;
          pred_phase = PH_DISCARD;
        end else begin
          pred_field_len  = b;
          pred_bytes_left = b;
          pred_value      = '0;
          pred_phase      = PH_PAYLOAD;
        end
      end
      PH_SKIP: begin
        if (pred_bytes_left != 8'd0) pred_bytes_left = pred_bytes_left - 8'd1;
        if (pred_bytes_left == 8'd0) begin
          if (p + 1 >= pred_declared) begin
            hit = 1'b1;
            res.kind = KIND_ABSENT;
            pred_phase = PH_DISCARD;
          end else begin
            pred_phase = PH_LENGTH;
          end
        end
      end
      PH_PAYLOAD: begin
        ix = int'(pred_field_len) - int'(pred_bytes_left);
        // the fourth byte joins the value only for a field of exactly four bytes
        if (ix < VALUE_BYTES || (ix == VALUE_BYTES && pred_field_len == FULL_WORD_LEN))
          pred_value = {pred_value[23:0], b};
        if (pred_bytes_left != 8'd0) pred_bytes_left = pred_bytes_left - 8'd1;
        hit = 1'b1;
        res.payload = b;
        if (pred_bytes_left == 8'd0) begin
          res.kind  = KIND_LAST;
          res.value = pred_value;
          pred_phase = PH_DISCARD;
        end else begin
          res.kind = KIND_BYTE;
        end
      end
      default: ;
    endcase
    if (p + 1 >= bl) begin
      pred_pos   = '0;
      pred_phase = PH_HEADER;
    end else begin
      pred_pos = 8'(p + 1);
    end
    return hit;
  endfunction

  // Offer one byte, hold it until accepted, then queue what it should produce.
  task automatic send_byte(input logic [7:0] data, input logic [7:0] blen,
                           input bit typed, input kind_t typed_kind);
    result_t res;
    bit      hit;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom_range(16'hFFFF));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {blen, data};
    @(posedge clk);
    while (!in_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    if (pred_phase != PH_DISCARD) parsed_bytes++;
    sent_bytes++;
    hit = predict_field_result(data, blen, res);
    if (typed) begin
      res = '0;
      res.kind = typed_kind;
      pending_results.push_back(res);
    end else if (hit) begin
      pending_results.push_back(res);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // bytes with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_field_skip(input logic [7:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    pred_field_skip = value;
    cfg_wr_en <= 1'b0;
    skip_writes++;
  endtask

  // Build one message: mostly well-formed field chains, some corrupted, cut short or noise.
  task automatic build_message(input bit force_big);
    int style;
    int len;
    int decl;
    int p;
    int n;
    int room;
    int k;
    msg_words.delete();
    message_count++;
    style = force_big ? 0 : $urandom_range(99);
    if (style >= 88) begin
      len = $urandom_range(0, 10);
      if (len == 0) msg_words.push_back({8'd0, 8'($urandom_range(255))});
      for (int i = 0; i < len; i++) msg_words.push_back({8'(len), 8'($urandom_range(255))});
      return;
    end
    if (force_big) len = $urandom_range(128, 255);
    else if (style >= 80 && $urandom_range(99) < 40) len = $urandom_range(17, 255);
    else len = $urandom_range(2, 16);
    decl = ($urandom_range(99) < 80) ? len : $urandom_range(2, len);
    msg_words.push_back({8'(len), 8'(decl)});
    p = 1;
    while (p < decl) begin
      room = decl - 1 - p;
      if ($urandom_range(99) < 80) n = $urandom_range(0, (room < 5) ? room : 5);
      else n = $urandom_range(0, room);
      msg_words.push_back({8'(len), 8'(n)});
      p++;
      for (int i = 0; i < n; i++) msg_words.push_back({8'(len), 8'($urandom_range(255))});
      p += n;
    end
    while (p < len) begin
      msg_words.push_back({8'(len), 8'($urandom_range(255))});
      p++;
    end
    if (style >= 70 && style < 80) begin
      k = $urandom_range(0, len - 1);
      msg_words[k][7:0] = 8'($urandom_range(255));
    end
    // end the message early by shrinking the buffer length on byte k
    if (style >= 80 && len >= 3) begin
      k = $urandom_range(1, (len - 2 < 12) ? len - 2 : 12);
      msg_words[k][15:8] = 8'(k + 1);
      while (msg_words.size() > k + 1) void'(msg_words.pop_back());
    end
  endtask

  // Receiver: random backpressure, plus long hold-offs on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold_reqs != long_holds_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_holds_done++;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : result_checker
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (out_tuser < 3'd5) kind_seen[out_tuser]++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: kind %0d", out_tuser);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[7:0] !== want.payload) begin
            $error("payload_byte: expected 0x%02h, got 0x%02h", want.payload, out_tdata[7:0]);
            mismatch_count++;
          end
          if (out_tdata[39:8] !== want.value) begin
            $error("int_value: expected 0x%08h, got 0x%08h", want.value, out_tdata[39:8]);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int phase_start;
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      case (directed_rows[r].op)
        STEP_SET_SKIP: set_field_skip(directed_rows[r].data);
        STEP_TYPED:    send_byte(directed_rows[r].data, directed_rows[r].blen, 1'b1,
                                 directed_rows[r].kind);
        default:       send_byte(directed_rows[r].data, directed_rows[r].blen, 1'b0, KIND_BYTE);
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_field_skip(8'(PHASE_SKIP[ph]));
      case (PHASE_IDLE[ph])
        IDLE_SENDER:   begin tx_idle_pct = 76; rx_stall_pct <= 0;  end
        IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct <= 76; end
        IDLE_BOTH:     begin tx_idle_pct = 19; rx_stall_pct <= 19; end
        default:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
      endcase
      // keep offering bytes while the receiver holds off, so the result queue fills
      if (PHASE_HOLD[ph]) long_hold_reqs <= long_hold_reqs + 1;
      phase_start = sent_bytes;
      build_message(PHASE_BIG[ph]);
      forever begin
        foreach (msg_words[i]) send_byte(msg_words[i][7:0], msg_words[i][15:8], 1'b0, KIND_BYTE);
        if (sent_bytes - phase_start >= PHASE_BYTES) break;
        build_message(1'b0);
      end
    end

    in_tvalid <= 1'b0;
    rx_stall_pct <= 0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end

    $display("Sent %0d bytes (%0d parsed) in %0d messages across %0d field_skip writes; input held off %0d cycles",
             sent_bytes, parsed_bytes, message_count, skip_writes, input_stalls);
    $display("Results seen: %0d payload, %0d final with value, %0d empty, %0d absent, %0d error",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (mismatch_count == 0) begin
      $display("length_prefixed_field_extractor_top: match");
    end else begin
      $display("length_prefixed_field_extractor_top: mismatch");
    end
    $finish;
  end

endmodule
